FILE: src/lrpf_pkg.sv
// Package for the line raster page framebuffer.
// Holds screen geometry, coordinate widths, item and pixel structs and clamp helpers.
// No dependencies.
package lrpf_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int X_W   = $clog2(SCREEN_WIDTH);
  localparam int Y_W   = ($clog2(SCREEN_HEIGHT) > 3) ? $clog2(SCREEN_HEIGHT) : 4;
  localparam int ERR_W = ((X_W > Y_W) ? X_W : Y_W) + 2;

  localparam int IN_X_W = 7;
  localparam int IN_Y_W = 6;
  localparam int COL_W  = 7;
  localparam int PAGE_W = 3;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic              kind;
    logic              set_mode;
    logic [IN_X_W-1:0] start_x;
    logic [IN_Y_W-1:0] start_y;
    logic [IN_X_W-1:0] end_x;
    logic [IN_Y_W-1:0] end_y;
  } item_t;

  typedef struct packed {
    addr_t             addr;
    logic [COL_W-1:0]  column;
    logic [PAGE_W-1:0] page;
    logic [7:0]        mask;
    logic              set;
    logic              last;
  } pix_t;

  typedef struct packed {
    logic       en;
    addr_t      addr;
    logic [7:0] data;
  } wr_t;

  function automatic logic [X_W-1:0] clamp_x(input logic [IN_X_W-1:0] v);
    if (int'(v) >= SCREEN_WIDTH) begin
      return X_W'(SCREEN_WIDTH - 1);
    end
    return X_W'(v);
  endfunction

  function automatic logic [Y_W-1:0] clamp_y(input logic [IN_Y_W-1:0] v);
    if (int'(v) >= SCREEN_HEIGHT) begin
      return Y_W'(SCREEN_HEIGHT - 1);
    end
    return Y_W'(v);
  endfunction

endpackage

FILE: src/lrpf_if.sv
// Handshake interfaces for line requests and pixel results.
// Depends on lrpf_pkg for field widths.
interface lrpf_item_if;
  import lrpf_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic              set_mode;
  logic [IN_X_W-1:0] start_x;
  logic [IN_Y_W-1:0] start_y;
  logic [IN_X_W-1:0] end_x;
  logic [IN_Y_W-1:0] end_y;

  modport source(output valid, kind, set_mode, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, kind, set_mode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lrpf_pixel_if;
  import lrpf_pkg::*;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  column;
  logic [PAGE_W-1:0] page;
  logic [7:0]        page_byte;
  logic              last_pixel;

  modport source(output valid, column, page, page_byte, last_pixel, input ready);
  modport sink(input valid, column, page, page_byte, last_pixel, output ready);
endinterface

FILE: src/lrpf_store.sv
// Frame store: synchronous page-byte memory with registered read data.
// Runs a clearing pass over every entry after reset. Depends on lrpf_pkg.
module lrpf_store (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  lrpf_pkg::addr_t rd_addr,
  output logic [7:0]      rd_data,
  input  lrpf_pkg::wr_t   wr,
  output logic            busy
);
  import lrpf_pkg::*;

  logic [7:0] mem [STORE_DEPTH];
  addr_t      clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 8'h00;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/lrpf_stepper.sv
// Line stepper: holds the Bresenham state and issues one pixel per start request and per
// advance request while a line is active. Depends on lrpf_pkg.
module lrpf_stepper (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  lrpf_pkg::item_t     item,
  output logic                issue,
  output lrpf_pkg::pix_t      pix
);
  import lrpf_pkg::*;

  logic [X_W-1:0]          cur_x, tgt_x, dlt_x;
  logic [Y_W-1:0]          cur_y, tgt_y, dlt_y;
  logic signed [1:0]       stp_x, stp_y;
  logic signed [ERR_W-1:0] err;
  logic                    active;
  logic                    mode;

  logic [X_W-1:0]          sx, ex, adx, x_next, tx_next;
  logic [Y_W-1:0]          sy, ey, ady, y_next, ty_next;
  logic signed [ERR_W-1:0] dxs, dys, err_s, err_a, err_next;
  logic signed [1:0]       dir_x, dir_y;
  logic signed [ERR_W:0]   e2, dx_e, dy_e;
  logic                    mv_x, mv_y;
  logic [X_W-1:0]          x_a;
  logic [Y_W-1:0]          y_a;
  logic                    is_start, last;

  always_comb begin
    is_start = (item.kind == KIND_START);
    sx = clamp_x(item.start_x);
    sy = clamp_y(item.start_y);
    ex = clamp_x(item.end_x);
    ey = clamp_y(item.end_y);
    dxs = $signed(ERR_W'(ex)) - $signed(ERR_W'(sx));
    dys = $signed(ERR_W'(ey)) - $signed(ERR_W'(sy));
    adx = (dxs < 0) ? X_W'(-dxs) : X_W'(dxs);
    ady = (dys < 0) ? Y_W'(-dys) : Y_W'(dys);
    dir_x = (dxs > 0) ? 2'sb01 : ((dxs < 0) ? 2'sb11 : 2'sb00);
    dir_y = (dys > 0) ? 2'sb01 : ((dys < 0) ? 2'sb11 : 2'sb00);
    err_s = $signed(ERR_W'(adx)) - $signed(ERR_W'(ady));

    e2   = {err, 1'b0};
    dx_e = $signed((ERR_W + 1)'(dlt_x));
    dy_e = $signed((ERR_W + 1)'(dlt_y));
    mv_x = (e2 > -dy_e);
    mv_y = (e2 < dx_e);
    err_a = err - (mv_x ? $signed(ERR_W'(dlt_y)) : '0)
                + (mv_y ? $signed(ERR_W'(dlt_x)) : '0);
    x_a = mv_x ? (cur_x + X_W'(stp_x)) : cur_x;
    y_a = mv_y ? (cur_y + Y_W'(stp_y)) : cur_y;

    x_next   = is_start ? sx : x_a;
    y_next   = is_start ? sy : y_a;
    tx_next  = is_start ? ex : tgt_x;
    ty_next  = is_start ? ey : tgt_y;
    err_next = is_start ? err_s : err_a;
    last     = (x_next == tx_next) && (y_next == ty_next);

    issue      = fire && (is_start || active);
    pix.addr   = ADDR_W'(int'(x_next) * PAGE_COUNT) + ADDR_W'(y_next[Y_W-1:3]);
    pix.column = COL_W'(x_next);
    pix.page   = PAGE_W'(y_next[Y_W-1:3]);
    pix.mask   = 8'(1) << y_next[2:0];
    pix.set    = is_start ? item.set_mode : mode;
    pix.last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x  <= '0;
      cur_y  <= '0;
      tgt_x  <= '0;
      tgt_y  <= '0;
      dlt_x  <= '0;
      dlt_y  <= '0;
      stp_x  <= '0;
      stp_y  <= '0;
      err    <= '0;
      active <= 1'b0;
      mode   <= 1'b0;
    end else if (issue) begin
      cur_x  <= x_next;
      cur_y  <= y_next;
      err    <= err_next;
      active <= !last;
      if (is_start) begin
        tgt_x <= ex;
        tgt_y <= ey;
        dlt_x <= adx;
        dlt_y <= ady;
        stp_x <= dir_x;
        stp_y <= dir_y;
        mode  <= item.set_mode;
      end
    end
  end

endmodule

FILE: src/lrpf_pixel.sv
// Pixel update stage: merges the read byte with the pixel mask, writes it back
// and holds the result in an output register. Depends on lrpf_pkg and lrpf_if.
module lrpf_pixel (
  input  logic           clk,
  input  logic           rst,
  input  logic           issue,
  input  lrpf_pkg::pix_t pix,
  input  logic [7:0]     rd_data,
  output logic           free,
  output lrpf_pkg::wr_t  wr,
  lrpf_pixel_if.source   pixels
);
  import lrpf_pkg::*;

  logic       b_valid;
  pix_t       b_pix;
  logic       fwd_valid;
  addr_t      fwd_addr;
  logic [7:0] fwd_data;
  logic       o_valid;
  logic       b_adv;
  logic [7:0] old_byte, new_byte;

  // A write retires on the same edge as the next read of that entry, so the
  // last written byte is kept and used when the addresses match.
  always_comb begin
    b_adv    = b_valid && (!o_valid || pixels.ready);
    free     = !b_valid || b_adv;
    old_byte = (fwd_valid && (fwd_addr == b_pix.addr)) ? fwd_data : rd_data;
    new_byte = b_pix.set ? (old_byte | b_pix.mask) : (old_byte & ~b_pix.mask);
    wr.en    = b_adv;
    wr.addr  = b_pix.addr;
    wr.data  = new_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      if (issue) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        fwd_valid <= 1'b1;
        o_valid   <= 1'b1;
      end else if (pixels.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_pix <= pix;
    end
    if (b_adv) begin
      fwd_addr          <= b_pix.addr;
      fwd_data          <= new_byte;
      pixels.column     <= b_pix.column;
      pixels.page       <= b_pix.page;
      pixels.page_byte  <= new_byte;
      pixels.last_pixel <= b_pix.last;
    end
  end

  assign pixels.valid = o_valid;

endmodule

FILE: src/line_raster_page_framebuffer.sv
// Bresenham line rasterizer over a page-organized monochrome frame store.
// A taken request's read byte and pixel are registered, then the merged byte goes to the
// output register. One request per cycle while the store is not clearing and the output
// is not stalled; each pixel is one read when taken and one write-back when it moves to
// the output, with the last write forwarded to the next read. Reset: line state clears at
// once; the store then clears one byte a cycle, ready low, over STORE_DEPTH (1024) entries.
module line_raster_page_framebuffer (
  input  logic         clk,
  input  logic         rst,
  lrpf_item_if.sink    items,
  lrpf_pixel_if.source pixels
);
  import lrpf_pkg::*;

  item_t      item;
  pix_t       pix;
  wr_t        wr;
  logic       fire, issue, free, busy;
  logic [7:0] rd_data;

  always_comb begin
    item.kind     = items.kind;
    item.set_mode = items.set_mode;
    item.start_x  = items.start_x;
    item.start_y  = items.start_y;
    item.end_x    = items.end_x;
    item.end_y    = items.end_y;
  end

  assign items.ready = !busy && free;
  assign fire        = items.valid && items.ready;

  lrpf_stepper u_stepper (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (item),
    .issue (issue),
    .pix   (pix)
  );

  lrpf_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (issue),
    .rd_addr (pix.addr),
    .rd_data (rd_data),
    .wr      (wr),
    .busy    (busy)
  );

  lrpf_pixel u_pixel (
    .clk     (clk),
    .rst     (rst),
    .issue   (issue),
    .pix     (pix),
    .rd_data (rd_data),
    .free    (free),
    .wr      (wr),
    .pixels  (pixels)
  );

endmodule
